@@ src/fma_pkg.sv @@
package fma_pkg;

    // Problem size.
    localparam int P_VARS       = 4;
    localparam int Q_VARS       = 2;
    localparam int WINDOW_DEPTH = 8;
    localparam int S_VARS       = P_VARS + Q_VARS;

    // Field widths.
    localparam int SMP_W = 16;
    localparam int ACC_W = 64;
    localparam int CNT_W = 32;
    localparam int LAM_W = 17;
    localparam int IDX_W = 7;
    localparam int LEN_W = 4;
    localparam int RFT_W = 16;

    // Stream payload widths.
    localparam int IN_DW  = S_VARS * SMP_W;
    localparam int IN_UW  = 2 + IDX_W;
    localparam int OUT_DW = ACC_W;

    // Accumulator store layout, also the read map for the lower indexes.
    localparam int XY_BASE   = P_VARS * P_VARS;
    localparam int SX_BASE   = XY_BASE + P_VARS * Q_VARS;
    localparam int SY_BASE   = SX_BASE + P_VARS;
    localparam int SQ_ADDR   = SY_BASE + Q_VARS;
    localparam int ACC_DEPTH = SQ_ADDR + 1;
    localparam int ACC_AW    = $clog2(ACC_DEPTH);
    localparam int RD_EFF    = ACC_DEPTH;
    localparam int RD_TOT    = ACC_DEPTH + 1;

    // Window store layout: all x rows, then all y rows.
    localparam int RD_WIN        = 64;
    localparam int WX_SIZE       = WINDOW_DEPTH * P_VARS;
    localparam int WIN_DEPTH_ALL = WINDOW_DEPTH * S_VARS;
    localparam int RD_END        = RD_WIN + WIN_DEPTH_ALL;
    localparam int WIN_AW        = $clog2(WIN_DEPTH_ALL);
    localparam int POS_W         = $clog2(WINDOW_DEPTH);

    // Step counters and sample selects.
    localparam int J_W    = $clog2(P_VARS);
    localparam int K_W    = $clog2((P_VARS > Q_VARS) ? P_VARS : Q_VARS);
    localparam int SEL_W  = $clog2(S_VARS + 1);
    localparam int SMP_IW = $clog2(S_VARS);
    localparam int SEL_ONE = S_VARS;

    // Shared multiplier: 33-bit by 18-bit signed.
    localparam int MUL_AW  = 33;
    localparam int MUL_BW  = 18;
    localparam int PROD_W  = MUL_AW + MUL_BW;
    localparam int PART_W  = 49;
    localparam int TERM_W  = 32;

    // Register reset values and the unity weight.
    localparam logic [LAM_W-1:0] LAMBDA_ONE = 17'h10000;
    localparam logic [LAM_W-1:0] LAMBDA_RST = 17'd64881;
    localparam logic [RFT_W-1:0] REFIT_RST  = 16'd10;

    // Configuration port.
    localparam int CFG_AW = 2;
    localparam int CFG_DW = LAM_W;

    typedef enum logic [CFG_AW-1:0] {
        CFG_LAMBDA,
        CFG_MODE,
        CFG_WLEN,
        CFG_REFIT
    } t_cfg_reg;

    typedef logic signed [SMP_W-1:0] t_sample;

    typedef enum logic [1:0] {
        MUL_TERM,
        MUL_LO,
        MUL_HI,
        MUL_EFF
    } t_mul_sel;

    typedef struct packed {
        logic     mul_en;
        t_mul_sel sel;
        logic     dec_en;
    } t_mac_ctrl;

endpackage

@@ src/forgetting_moment_accumulator.sv @@
// Exponentially weighted covariance accumulator with a moving-window sample
// store. All 31 accumulators sit in one 64-bit RAM and are updated by a
// read-decay-add-write sequence through a single shared 33x18 multiplier,
// stepping through the states S_RD, S_MLO, S_MHI, S_DEC and S_WR for each
// accumulator. An update in forgetting mode first scales the effective count
// (S_CNT, S_CNT2) and then visits 20 accumulator entries without a response
// vector and 32 with one, before its result goes to the output register.
// A window-mode update writes one sample element per cycle into the window RAM
// (P elements, or P+Q with a response vector). An update in neither mode only
// advances the refit count, and a read item fetches one value. One item is
// processed at a time; the next item is accepted while the previous result
// still waits in the output register.
// Both RAMs come out of reset reading as zero through per-entry valid flags,
// so no clearing pass is needed. Configuration writes are always ready.
module forgetting_moment_accumulator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // tdata: x_0, x_1, x_2, x_3, y_0, y_1 (16 bits each, from bit 0 up)
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [fma_pkg::IN_DW-1:0]    s_axis_tdata,
    // tuser: opcode [0], y_present [1], read_index [8:2]
    input  logic [fma_pkg::IN_UW-1:0]    s_axis_tuser,
    // tdata: read_value [63:0]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [fma_pkg::OUT_DW-1:0]   m_axis_tdata,
    // tuser: refit_due [0]
    output logic [0:0]                   m_axis_tuser,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [fma_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [fma_pkg::CFG_DW-1:0]   i_cfg_data
);

    import fma_pkg::*;

    localparam logic OP_READ = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_QRD,
        S_QDAT,
        S_CNT,
        S_CNT2,
        S_RD,
        S_MLO,
        S_MHI,
        S_DEC,
        S_WR,
        S_WIN,
        S_FIN,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_XX,
        PH_XY,
        PH_SX,
        PH_SY,
        PH_SQ
    } t_phase;

    typedef enum logic [2:0] {
        QK_ACC,
        QK_WIN,
        QK_EFF,
        QK_TOT,
        QK_ZERO
    } t_qkind;

    // Control state.
    t_state             r_state;
    t_phase             r_phase;
    logic [J_W-1:0]     r_j;
    logic [K_W-1:0]     r_k;
    logic [SEL_W-1:0]   r_wc;
    t_qkind             r_qkind;
    logic               r_rd_vld;
    logic               r_acc_vld [ACC_DEPTH];
    logic               r_win_vld [WIN_DEPTH_ALL];

    // Configuration registers.
    logic [LAM_W-1:0]   r_lambda;
    logic               r_exp_mode;
    logic [LEN_W-1:0]   r_win_len;
    logic [RFT_W-1:0]   r_refit_int;

    // Counters.
    logic [CNT_W-1:0]   r_eff;
    logic [CNT_W-1:0]   r_total;
    logic [RFT_W-1:0]   r_since;
    logic [POS_W-1:0]   r_wpos;

    // Item payload and result.
    t_sample            r_smp [S_VARS];
    logic               r_ypres;
    logic [IDX_W-1:0]   r_idx;
    t_sample            r_opa;
    logic [ACC_W-1:0]   r_res_val;
    logic               r_res_due;
    logic               r_m_valid;
    logic [OUT_DW-1:0]  r_m_data;
    logic               r_m_user;

    // Combinational signals.
    logic [LAM_W-1:0]   lam;
    logic [ACC_AW-1:0]  step_addr;
    logic [SEL_W-1:0]   sel_a;
    logic [SEL_W-1:0]   sel_b;
    logic [LAM_W-1:0]   step_lam;
    logic               step_last;
    t_phase             n_phase;
    logic [J_W-1:0]     n_j;
    logic [K_W-1:0]     n_k;
    logic [SEL_W-1:0]   rd_sel;
    t_sample            smp_val;
    logic [LEN_W-1:0]   wlen;
    logic [POS_W-1:0]   wpos;
    logic [LEN_W-1:0]   wpos_inc;
    logic [POS_W-1:0]   n_wpos;
    logic [WIN_AW-1:0]  win_waddr;
    logic               win_last;
    logic [RFT_W:0]     n_since;
    logic               acc_re;
    logic [ACC_AW-1:0]  acc_raddr;
    logic [ACC_W-1:0]   acc_rdata;
    logic               win_re;
    logic [WIN_AW-1:0]  win_raddr;
    logic [SMP_W-1:0]   win_rdata;
    t_mac_ctrl          mac_ctrl;
    logic [ACC_W-1:0]   mac_acc;
    logic [ACC_W-1:0]   mac_sum;
    logic [CNT_W-1:0]   mac_eff;

    assign lam = (r_lambda > LAMBDA_ONE) ? LAMBDA_ONE : r_lambda;

    // Step sequencer: address, operands and next step for each accumulator.
    always_comb begin
        step_addr = '0;
        sel_a     = '0;
        sel_b     = '0;
        step_lam  = lam;
        step_last = 1'b0;
        n_phase   = r_phase;
        n_j       = r_j;
        n_k       = r_k;
        unique case (r_phase)
            PH_XX: begin
                step_addr = ACC_AW'(int'(r_j) * P_VARS + int'(r_k));
                sel_a     = SEL_W'(r_j);
                sel_b     = SEL_W'(r_k);
                if (r_k == K_W'(P_VARS - 1)) begin
                    n_k = '0;
                    if (r_j == J_W'(P_VARS - 1)) begin
                        n_j     = '0;
                        n_phase = r_ypres ? PH_XY : PH_SX;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            PH_XY: begin
                step_addr = ACC_AW'(XY_BASE + int'(r_j) * Q_VARS + int'(r_k));
                sel_a     = SEL_W'(r_j);
                sel_b     = SEL_W'(P_VARS + int'(r_k));
                if (r_k == K_W'(Q_VARS - 1)) begin
                    n_k = '0;
                    if (r_j == J_W'(P_VARS - 1)) begin
                        n_j     = '0;
                        n_phase = PH_SX;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            PH_SX: begin
                step_addr = ACC_AW'(SX_BASE + int'(r_j));
                sel_a     = SEL_W'(r_j);
                sel_b     = SEL_W'(SEL_ONE);
                if (r_j == J_W'(P_VARS - 1)) begin
                    n_j = '0;
                    n_k = '0;
                    if (r_ypres) begin
                        n_phase = PH_SY;
                    end else begin
                        step_last = 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            PH_SY: begin
                step_addr = ACC_AW'(SY_BASE + int'(r_k));
                sel_a     = SEL_W'(P_VARS + int'(r_k));
                sel_b     = SEL_W'(SEL_ONE);
                if (r_k == K_W'(Q_VARS - 1)) begin
                    n_k     = '0;
                    n_phase = PH_SQ;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            PH_SQ: begin
                // The square sum decays on its first visit only.
                step_addr = ACC_AW'(SQ_ADDR);
                sel_a     = SEL_W'(P_VARS + int'(r_k));
                sel_b     = SEL_W'(P_VARS + int'(r_k));
                step_lam  = (r_k == '0) ? lam : LAMBDA_ONE;
                if (r_k == K_W'(Q_VARS - 1)) begin
                    n_k       = '0;
                    step_last = 1'b1;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            default: begin
                step_last = 1'b1;
            end
        endcase
    end

    // One read of the sample registers per cycle; the top code reads as one.
    always_comb begin
        if (r_state == S_WIN) begin
            rd_sel = r_wc;
        end else if (r_state == S_DEC) begin
            rd_sel = sel_b;
        end else begin
            rd_sel = sel_a;
        end
        if (rd_sel >= SEL_W'(S_VARS)) begin
            smp_val = 16'sd1;
        end else begin
            smp_val = r_smp[rd_sel[SMP_IW-1:0]];
        end
    end

    // Ring position and write address of the window store.
    assign wlen     = (r_win_len > LEN_W'(WINDOW_DEPTH)) ? LEN_W'(WINDOW_DEPTH) : r_win_len;
    assign wpos     = (LEN_W'(r_wpos) < wlen) ? r_wpos : '0;
    assign wpos_inc = LEN_W'(wpos) + 1'b1;
    assign n_wpos   = (wpos_inc == wlen) ? '0 : wpos_inc[POS_W-1:0];
    assign win_last = (r_wc == SEL_W'(S_VARS - 1)) ||
                      (!r_ypres && (r_wc == SEL_W'(P_VARS - 1)));

    always_comb begin
        if (r_wc < SEL_W'(P_VARS)) begin
            win_waddr = WIN_AW'(int'(wpos) * P_VARS + int'(r_wc));
        end else begin
            win_waddr = WIN_AW'(WX_SIZE + int'(wpos) * Q_VARS + int'(r_wc) - P_VARS);
        end
    end

    assign n_since = {1'b0, r_since} + 1'b1;

    // Memory ports.
    assign acc_re    = (r_state == S_RD) || (r_state == S_QRD);
    assign acc_raddr = (r_state == S_QRD) ? r_idx[ACC_AW-1:0] : step_addr;
    assign win_re    = (r_state == S_QRD);
    assign win_raddr = WIN_AW'(r_idx - IDX_W'(RD_WIN));

    fma_ram #(
        .WIDTH (ACC_W),
        .DEPTH (ACC_DEPTH)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WR),
        .i_waddr (step_addr),
        .i_wdata (mac_sum),
        .i_re    (acc_re),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    fma_ram #(
        .WIDTH (SMP_W),
        .DEPTH (WIN_DEPTH_ALL)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WIN),
        .i_waddr (win_waddr),
        .i_wdata (smp_val),
        .i_re    (win_re),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    // Multiply-accumulate control per sequencer state.
    always_comb begin
        mac_ctrl = '{mul_en: 1'b0, sel: MUL_TERM, dec_en: 1'b0};
        unique case (r_state)
            S_CNT:   mac_ctrl = '{mul_en: 1'b1, sel: MUL_EFF,  dec_en: 1'b0};
            S_MLO:   mac_ctrl = '{mul_en: 1'b1, sel: MUL_LO,   dec_en: 1'b0};
            S_MHI:   mac_ctrl = '{mul_en: 1'b1, sel: MUL_HI,   dec_en: 1'b0};
            S_DEC:   mac_ctrl = '{mul_en: 1'b1, sel: MUL_TERM, dec_en: 1'b1};
            default: mac_ctrl = '{mul_en: 1'b0, sel: MUL_TERM, dec_en: 1'b0};
        endcase
    end

    assign mac_acc = r_rd_vld ? acc_rdata : '0;

    fma_mac u_mac (
        .i_clk      (i_clk),
        .i_ctrl     (mac_ctrl),
        .i_acc      (mac_acc),
        .i_lam      (step_lam),
        .i_eff      (r_eff),
        .i_op_a     (r_opa),
        .i_op_b     (smp_val),
        .o_sum      (mac_sum),
        .o_eff_next (mac_eff)
    );

    // Sequencer, configuration registers and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_XX;
            r_j         <= '0;
            r_k         <= '0;
            r_wc        <= '0;
            r_qkind     <= QK_ZERO;
            r_rd_vld    <= 1'b0;
            r_lambda    <= LAMBDA_RST;
            r_exp_mode  <= 1'b1;
            r_win_len   <= '0;
            r_refit_int <= REFIT_RST;
            r_eff       <= '0;
            r_total     <= '0;
            r_since     <= '0;
            r_wpos      <= '0;
            r_m_valid   <= 1'b0;
            for (int i = 0; i < ACC_DEPTH; i++) begin
                r_acc_vld[i] <= 1'b0;
            end
            for (int i = 0; i < WIN_DEPTH_ALL; i++) begin
                r_win_vld[i] <= 1'b0;
            end
        end else begin
            // Configuration writes.
            if (i_cfg_valid) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    CFG_LAMBDA: r_lambda    <= i_cfg_data;
                    CFG_MODE:   r_exp_mode  <= i_cfg_data[0];
                    CFG_WLEN:   r_win_len   <= i_cfg_data[LEN_W-1:0];
                    CFG_REFIT:  r_refit_int <= i_cfg_data[RFT_W-1:0];
                endcase
            end

            // Result beat taken downstream; in S_OUT the load below decides.
            if (r_m_valid && m_axis_tready && (r_state != S_OUT)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        for (int i = 0; i < S_VARS; i++) begin
                            r_smp[i] <= s_axis_tdata[i*SMP_W +: SMP_W];
                        end
                        r_ypres <= s_axis_tuser[1];
                        r_idx   <= s_axis_tuser[IN_UW-1:2];
                        r_wc    <= '0;
                        if (s_axis_tuser[0] == OP_READ) begin
                            r_state <= S_QRD;
                        end else if (r_exp_mode) begin
                            r_state <= S_CNT;
                        end else if (r_win_len != '0) begin
                            r_state <= S_WIN;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_QRD: begin
                    priority if (r_idx < IDX_W'(ACC_DEPTH)) begin
                        r_qkind  <= QK_ACC;
                        r_rd_vld <= r_acc_vld[r_idx[ACC_AW-1:0]];
                    end else if (r_idx == IDX_W'(RD_EFF)) begin
                        r_qkind <= QK_EFF;
                    end else if (r_idx == IDX_W'(RD_TOT)) begin
                        r_qkind <= QK_TOT;
                    end else if (r_idx >= IDX_W'(RD_WIN) && r_idx < IDX_W'(RD_END)) begin
                        r_qkind  <= QK_WIN;
                        r_rd_vld <= r_win_vld[win_raddr];
                    end else begin
                        r_qkind <= QK_ZERO;
                    end
                    r_state <= S_QDAT;
                end
                S_QDAT: begin
                    unique case (r_qkind)
                        QK_ACC:  r_res_val <= r_rd_vld ? acc_rdata : '0;
                        QK_WIN:  r_res_val <= r_rd_vld ?
                                              {{(ACC_W-SMP_W){win_rdata[SMP_W-1]}}, win_rdata} :
                                              '0;
                        QK_EFF:  r_res_val <= {{(ACC_W-CNT_W){1'b0}}, r_eff};
                        QK_TOT:  r_res_val <= {{(ACC_W-CNT_W){1'b0}}, r_total};
                        default: r_res_val <= '0;
                    endcase
                    r_res_due <= 1'b0;
                    r_state   <= S_OUT;
                end
                S_CNT: begin
                    r_state <= S_CNT2;
                end
                S_CNT2: begin
                    r_eff   <= mac_eff;
                    r_total <= r_total + 1'b1;
                    r_phase <= PH_XX;
                    r_j     <= '0;
                    r_k     <= '0;
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_opa    <= smp_val;
                    r_rd_vld <= r_acc_vld[step_addr];
                    r_state  <= S_MLO;
                end
                S_MLO: begin
                    r_state <= S_MHI;
                end
                S_MHI: begin
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_acc_vld[step_addr] <= 1'b1;
                    r_phase <= n_phase;
                    r_j     <= n_j;
                    r_k     <= n_k;
                    r_state <= step_last ? S_FIN : S_RD;
                end
                S_WIN: begin
                    r_win_vld[win_waddr] <= 1'b1;
                    if (win_last) begin
                        r_wpos  <= n_wpos;
                        r_total <= r_total + 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_wc <= r_wc + 1'b1;
                    end
                end
                S_FIN: begin
                    // Refit request once the interval count is reached.
                    if (n_since >= {1'b0, r_refit_int}) begin
                        r_since   <= '0;
                        r_res_due <= 1'b1;
                    end else begin
                        r_since   <= n_since[RFT_W-1:0];
                        r_res_due <= 1'b0;
                    end
                    r_res_val <= '0;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_data  <= r_res_val;
                        r_m_user  <= r_res_due;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign s_axis_tready   = (r_state == S_IDLE);
    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_user;
    assign o_cfg_ready     = 1'b1;

endmodule

@@ src/fma_ram.sv @@
module fma_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fma_mac.sv @@
module fma_mac (
    input  logic                       i_clk,
    input  fma_pkg::t_mac_ctrl         i_ctrl,
    input  logic [fma_pkg::ACC_W-1:0]  i_acc,
    input  logic [fma_pkg::LAM_W-1:0]  i_lam,
    input  logic [fma_pkg::CNT_W-1:0]  i_eff,
    input  fma_pkg::t_sample           i_op_a,
    input  fma_pkg::t_sample           i_op_b,
    output logic [fma_pkg::ACC_W-1:0]  o_sum,
    output logic [fma_pkg::CNT_W-1:0]  o_eff_next
);

    import fma_pkg::*;

    logic signed [MUL_AW-1:0] m_a;
    logic signed [MUL_BW-1:0] m_b;
    logic signed [PROD_W-1:0] m_p;
    logic [ACC_W+1:0]         dec_full;
    logic [ACC_W:0]           sum_full;
    logic [CNT_W:0]           eff_full;

    logic signed [TERM_W-1:0] r_term;
    logic [PART_W-1:0]        r_plo;
    logic [PART_W-1:0]        r_phi;
    logic [ACC_W-1:0]         r_dec;

    // Operand selection for the single shared multiplier.
    always_comb begin
        m_b = (i_ctrl.sel == MUL_TERM) ? {{(MUL_BW-SMP_W){i_op_b[SMP_W-1]}}, i_op_b}
                                       : {1'b0, i_lam};
        unique case (i_ctrl.sel)
            MUL_TERM: m_a = {{(MUL_AW-SMP_W){i_op_a[SMP_W-1]}}, i_op_a};
            MUL_LO:   m_a = {1'b0, i_acc[31:0]};
            MUL_HI:   m_a = {i_acc[ACC_W-1], i_acc[ACC_W-1:32]};
            MUL_EFF:  m_a = {1'b0, i_eff};
        endcase
    end

    assign m_p = m_a * m_b;

    // Decay: floor(acc * lambda / 2^16) from the two half products.
    assign dec_full = {r_phi[PART_W-1], r_phi, 16'b0} + {33'b0, r_plo[PART_W-1:16]};

    // Saturating add of the new term to the decayed accumulator.
    assign sum_full = {r_dec[ACC_W-1], r_dec} + {{(ACC_W+1-TERM_W){r_term[TERM_W-1]}}, r_term};

    always_comb begin
        if (sum_full[ACC_W] != sum_full[ACC_W-1]) begin
            o_sum = sum_full[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            o_sum = sum_full[ACC_W-1:0];
        end
    end

    // Effective count: floor(n * lambda / 2^16) + 1, saturating at 32 bits.
    assign eff_full   = r_plo[PART_W-1:16] + 33'd1;
    assign o_eff_next = eff_full[CNT_W] ? {CNT_W{1'b1}} : eff_full[CNT_W-1:0];

    // Product and decay registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            unique case (i_ctrl.sel)
                MUL_TERM: r_term <= m_p[TERM_W-1:0];
                MUL_LO:   r_plo  <= m_p[PART_W-1:0];
                MUL_HI:   r_phi  <= m_p[PART_W-1:0];
                MUL_EFF:  r_plo  <= m_p[PART_W-1:0];
            endcase
        end
        if (i_ctrl.dec_en) begin
            r_dec <= dec_full[ACC_W-1:0];
        end
    end

endmodule
